[hw/rtl/ebnf_grammar_tokenizer_top_defines.svh]
// Assertion macros shared by the tokenizer RTL.
// No dependencies; the including module must provide clk_i and rst_ni.
`ifndef EBNF_GRAMMAR_TOKENIZER_TOP_DEFINES_SVH
`define EBNF_GRAMMAR_TOKENIZER_TOP_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define EGT_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define EGT_ASSERT(label, prop, msg) \
  `EGT_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/egt_pkg.sv]
// Types, codes and per-character lexer functions of the grammar tokenizer.
// No dependencies; imported by ebnf_grammar_tokenizer_top.
package egt_pkg;

  // Token length limit and the saturation point of the 8-bit length field.
  localparam int MAX_TOKEN_LEN = 255;
  localparam int LEN_W         = 8;
  localparam int LEN_CAP       = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes.
  localparam logic REG_KEEP_WS = 1'b0;

  // Token kinds.
  localparam logic [3:0] KIND_IDENT   = 4'd0;
  localparam logic [3:0] KIND_SQ      = 4'd1;
  localparam logic [3:0] KIND_DQ      = 4'd2;
  localparam logic [3:0] KIND_COMMA   = 4'd3;
  localparam logic [3:0] KIND_SEMI    = 4'd4;
  localparam logic [3:0] KIND_BAR     = 4'd5;
  localparam logic [3:0] KIND_MINUS   = 4'd6;
  localparam logic [3:0] KIND_EQUALS  = 4'd7;
  localparam logic [3:0] KIND_PAREN   = 4'd8;
  localparam logic [3:0] KIND_CURLY   = 4'd9;
  localparam logic [3:0] KIND_SQUARE  = 4'd10;
  localparam logic [3:0] KIND_SPACE   = 4'd11;
  localparam logic [3:0] KIND_NONE    = 4'd12;

  // Error codes.
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_UNRECOG     = 2'd1;
  localparam logic [1:0] ERR_UNCLOSED_SQ = 2'd2;
  localparam logic [1:0] ERR_UNCLOSED_DQ = 2'd3;

  // Request types.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_EOI  = 1'b1;

  // Characters the lexer knows by value.
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_BAR     = 8'h7C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Lexer mode, one-hot.
  typedef enum logic [5:0] {
    MODE_IDLE  = 6'b000001,
    MODE_HASH  = 6'b000010,
    MODE_IDENT = 6'b000100,
    MODE_SQ    = 6'b001000,
    MODE_DQ    = 6'b010000,
    MODE_ERR   = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [3:0]       kind;
    logic [LEN_W-1:0] len;
    logic             sat;
    logic [1:0]       err;
  } result_t;

  typedef struct packed {
    result_t res;
    logic    last;
  } out_item_t;

  typedef struct packed {
    mode_e            mode;
    logic [LEN_W-1:0] count;
    logic             ovf;
  } lex_state_t;

  // Outcome of one lexer step: new state and up to two results.
  typedef struct packed {
    lex_state_t st;
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } lex_out_t;

  function automatic result_t mk_result(input logic [3:0] kind,
                                        input logic [LEN_W-1:0] len,
                                        input logic sat,
                                        input logic [1:0] err);
    result_t r;
    r.kind = kind;
    r.len  = len;
    r.sat  = sat;
    r.err  = err;
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_ident_tail(input logic [7:0] c);
    return is_letter(c) || (c inside {[8'h30:8'h39]}) || (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

  // Count one more token character, saturating at the cap.
  function automatic lex_state_t bump(input lex_state_t st);
    lex_state_t o;
    o = st;
    if (st.count >= LEN_W'(LEN_CAP)) begin
      o.ovf = 1'b1;
    end else begin
      o.count = st.count + LEN_W'(1);
    end
    return o;
  endfunction

  // Start a new token on character c from the idle mode.
  function automatic lex_out_t lex_begin(input logic [7:0] c, input logic keep_ws);
    lex_out_t   o;
    logic [3:0] kind;
    o.st.mode  = MODE_IDLE;
    o.st.count = LEN_W'(1);
    o.st.ovf   = 1'b0;
    o.n        = 2'd0;
    o.r0       = mk_result(KIND_NONE, '0, 1'b0, ERR_NONE);
    o.r1       = o.r0;
    kind       = KIND_NONE;
    case (c)
      CH_HASH:              o.st.mode = MODE_HASH;
      CH_SQUOTE:            o.st.mode = MODE_SQ;
      CH_DQUOTE:            o.st.mode = MODE_DQ;
      CH_COMMA:             kind = KIND_COMMA;
      CH_SEMI:              kind = KIND_SEMI;
      CH_BAR:               kind = KIND_BAR;
      CH_MINUS:             kind = KIND_MINUS;
      CH_EQUALS:            kind = KIND_EQUALS;
      CH_LPAREN, CH_RPAREN: kind = KIND_PAREN;
      CH_LCURLY, CH_RCURLY: kind = KIND_CURLY;
      CH_LSQUARE, CH_RSQUARE: kind = KIND_SQUARE;
      default: ;
    endcase
    if (o.st.mode == MODE_IDLE) begin
      if (kind != KIND_NONE) begin
        o.n  = 2'd1;
        o.r0 = mk_result(kind, LEN_W'(1), 1'b0, ERR_NONE);
      end else if (is_space(c)) begin
        if (keep_ws) begin
          o.n  = 2'd1;
          o.r0 = mk_result(KIND_SPACE, LEN_W'(1), 1'b0, ERR_NONE);
        end
      end else begin
        o.n       = 2'd1;
        o.r0      = mk_result(KIND_NONE, '0, 1'b0, ERR_UNRECOG);
        o.st.mode = MODE_ERR;
      end
    end
    return o;
  endfunction

  // One character through the lexer from state st.
  function automatic lex_out_t lex_step(input lex_state_t st, input logic [7:0] c,
                                        input logic keep_ws);
    lex_out_t   o;
    lex_out_t   b;
    lex_state_t nb;
    o.st = st;
    o.n  = 2'd0;
    o.r0 = mk_result(KIND_NONE, '0, 1'b0, ERR_NONE);
    o.r1 = o.r0;
    b    = lex_begin(c, keep_ws);
    nb   = bump(st);
    case (st.mode)
      MODE_ERR: ;
      MODE_HASH: begin
        if (is_letter(c)) begin
          o.st      = nb;
          o.st.mode = MODE_IDENT;
        end else begin
          o.n       = 2'd1;
          o.r0      = mk_result(KIND_NONE, '0, 1'b0, ERR_UNRECOG);
          o.st.mode = MODE_ERR;
        end
      end
      MODE_IDENT: begin
        if (is_ident_tail(c)) begin
          o.st = nb;
        end else begin
          // The identifier ends here and c opens the next token.
          o.st = b.st;
          o.n  = b.n + 2'd1;
          o.r0 = mk_result(KIND_IDENT, st.count, st.ovf, ERR_NONE);
          o.r1 = b.r0;
        end
      end
      MODE_SQ, MODE_DQ: begin
        o.st = nb;
        if ((st.mode == MODE_SQ && c == CH_SQUOTE) ||
            (st.mode == MODE_DQ && c == CH_DQUOTE)) begin
          o.n       = 2'd1;
          o.r0      = mk_result((st.mode == MODE_SQ) ? KIND_SQ : KIND_DQ,
                                nb.count, nb.ovf, ERR_NONE);
          o.st.mode = MODE_IDLE;
        end
      end
      default: o = b;
    endcase
    return o;
  endfunction

endpackage

[hw/rtl/ebnf_grammar_tokenizer_top.sv]
// Streaming grammar tokenizer: comment strip, lexer and result queue.
// Depends on egt_pkg and ebnf_grammar_tokenizer_top_defines.svh.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         in_valid_i / in_stall_o   req_type_i, char_byte_i
//   result    out        out_valid_o / out_stall_i token_kind_o .. is_last_o
//   config    in         APB psel/penable/pready   paddr, pwdata, prdata
//
// One item is taken per cycle while in_stall_o is low; its zero to two
// results land in a four-entry result queue in the same edge and leave it
// one per cycle while out_stall_i is low. The input stalls while fewer than
// two queue entries are free, so an item with two results always has room.
// Reset clears the lexer state, the queue pointers and keep_whitespace.
// A result waits in the queue while out_stall_i is high; input keeps flowing
// until three entries are held.

`include "ebnf_grammar_tokenizer_top_defines.svh"

module ebnf_grammar_tokenizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  char_byte_i,
  // Result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [egt_pkg::LEN_W-1:0] token_length_o,
  output logic        length_saturated_o,
  output logic [1:0]  error_code_o,
  output logic        is_last_o,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import egt_pkg::*;

  // Configuration register.
  logic keep_ws_q;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_KEEP_WS);
  assign prdata = (paddr[2] == REG_KEEP_WS) ? {31'b0, keep_ws_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_ws_q <= 1'b0;
    end else if (cfg_we) begin
      keep_ws_q <= pwdata[0];
    end
  end

  // Stream state.
  lex_state_t st_q, st_d;
  logic       slash_q, slash_d;
  logic       inlc_q, inlc_d;

  // Result queue.
  out_item_t        fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  logic in_acc, out_acc, is_eoi, not_err;
  logic eoi_acc, st_clear;
  logic do_a, do_b;
  lex_out_t   lex_a, lex_b;
  lex_state_t st_s1;
  logic [1:0] na, nb, push_n;
  result_t    b_r0, b_r1, res0, res1, flush_r, none_r;
  logic       flush_v;

  assign in_stall_o = (cnt_q > CNT_W'(FIFO_DEPTH - 2));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc    = out_valid_o && !out_stall_i;
  assign is_eoi     = (req_type_i == REQ_EOI);
  assign not_err    = (st_q.mode != MODE_ERR);

  // A held slash goes to the lexer when the next byte is not a slash, or at
  // end of input; the current byte follows it unless a comment swallows it.
  assign do_a = not_err && slash_q && !inlc_q && (is_eoi || char_byte_i != CH_SLASH);
  assign do_b = !is_eoi && not_err &&
                (inlc_q ? (char_byte_i == CH_NEWLINE) : (char_byte_i != CH_SLASH));

  assign lex_a = lex_step(st_q, CH_SLASH, keep_ws_q);
  assign st_s1 = do_a ? lex_a.st : st_q;
  assign na    = do_a ? lex_a.n : 2'd0;
  assign lex_b = lex_step(st_s1, char_byte_i, keep_ws_q);

  // End-of-input flush of whatever token is open.
  always_comb begin
    flush_v = 1'b1;
    flush_r = mk_result(KIND_NONE, '0, 1'b0, ERR_NONE);
    case (st_s1.mode)
      MODE_IDENT: flush_r = mk_result(KIND_IDENT, st_s1.count, st_s1.ovf, ERR_NONE);
      MODE_HASH:  flush_r = mk_result(KIND_NONE, '0, 1'b0, ERR_UNRECOG);
      MODE_SQ:    flush_r = mk_result(KIND_NONE, '0, 1'b0, ERR_UNCLOSED_SQ);
      MODE_DQ:    flush_r = mk_result(KIND_NONE, '0, 1'b0, ERR_UNCLOSED_DQ);
      default:    flush_v = 1'b0;
    endcase
  end

  // Second result source: the byte's own lexer step, or the flush.
  always_comb begin
    none_r = mk_result(KIND_NONE, '0, 1'b0, ERR_NONE);
    b_r1   = lex_b.r1;
    if (is_eoi) begin
      b_r0 = flush_v ? flush_r : none_r;
      nb   = (flush_v || na == 2'd0) ? 2'd1 : 2'd0;
    end else begin
      b_r0 = lex_b.r0;
      nb   = do_b ? lex_b.n : 2'd0;
    end
  end

  // Merge the two sources in order; together they never exceed two.
  always_comb begin
    res0   = (na != 2'd0) ? lex_a.r0 : b_r0;
    res1   = (na == 2'd2) ? lex_a.r1 : ((na == 2'd1) ? b_r0 : b_r1);
    push_n = in_acc ? (na + nb) : 2'd0;
  end

  // Next stream state.
  always_comb begin
    st_d    = st_q;
    slash_d = slash_q;
    inlc_d  = inlc_q;
    if (in_acc) begin
      if (is_eoi) begin
        st_d.mode  = MODE_IDLE;
        st_d.count = '0;
        st_d.ovf   = 1'b0;
        slash_d    = 1'b0;
        inlc_d     = 1'b0;
      end else if (not_err) begin
        st_d = do_b ? lex_b.st : st_s1;
        if (inlc_q) begin
          inlc_d = (char_byte_i != CH_NEWLINE);
        end else begin
          inlc_d  = slash_q && (char_byte_i == CH_SLASH);
          slash_d = !slash_q && (char_byte_i == CH_SLASH);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode  <= MODE_IDLE;
      st_q.count <= '0;
      st_q.ovf   <= 1'b0;
      slash_q    <= 1'b0;
      inlc_q     <= 1'b0;
    end else begin
      st_q    <= st_d;
      slash_q <= slash_d;
      inlc_q  <= inlc_d;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + PTR_W'(out_acc);
      cnt_q    <= cnt_q + CNT_W'(push_n) - CNT_W'(out_acc);
    end
  end

  // Queue storage; the last result of a stream carries the end mark.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= '{res: res0, last: is_eoi && (push_n == 2'd1)};
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + PTR_W'(1)] <= '{res: res1, last: is_eoi};
    end
  end

  assign token_kind_o       = fifo_q[rd_ptr_q].res.kind;
  assign token_length_o     = fifo_q[rd_ptr_q].res.len;
  assign length_saturated_o = fifo_q[rd_ptr_q].res.sat;
  assign error_code_o       = fifo_q[rd_ptr_q].res.err;
  assign is_last_o          = fifo_q[rd_ptr_q].last;

  // Checks on the queue and the stream state.
  assign eoi_acc  = in_acc && is_eoi;
  assign st_clear = (st_q.mode == MODE_IDLE) && !slash_q && !inlc_q;

  `EGT_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(FIFO_DEPTH), "result queue overfilled")
  `EGT_ASSERT(a_eoi_pushes, eoi_acc |-> (push_n != 2'd0), "end of input gave no result")
  `EGT_ASSERT(a_eoi_clears, eoi_acc |=> st_clear, "stream state not cleared after end of input")
  `EGT_ASSERT(a_slash_comment, !(slash_q && inlc_q), "slash held inside a line comment")

endmodule
